// ===== design/page_minmax_range_filter_top_macros.svh =====
// ----------------------------------------------------------------------------
// Page min/max range filter: assertion macros
// Clocked on clk, quiet while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef PAGE_MINMAX_RANGE_FILTER_TOP_MACROS_SVH
`define PAGE_MINMAX_RANGE_FILTER_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent
`define PMMRF_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define PMMRF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/pmmrf_pkg.sv =====
// ----------------------------------------------------------------------------
// pmmrf_pkg
// Shared types, codes and compare helpers for the page min/max range filter.
// ----------------------------------------------------------------------------
package pmmrf_pkg;

    // Field widths of the transaction ports
    localparam int VALUE_W  = 64;
    localparam int LEN_W    = 4;
    localparam int INDEX_W  = 10;
    localparam int STORED_W = 11;
    localparam int STATUS_W = 2;

    // Function codes
    localparam logic FUNC_APPEND = 1'b0;
    localparam logic FUNC_QUERY  = 1'b1;

    // Status codes
    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

    // Compare outcomes
    typedef logic [1:0] cmp_t;
    localparam cmp_t CMP_LT = 2'd0;
    localparam cmp_t CMP_EQ = 2'd1;
    localparam cmp_t CMP_GT = 2'd2;

    // Per-page metadata held beside the bound values
    typedef struct packed {
        logic             null_flag;
        logic [LEN_W-1:0] min_len;
        logic [LEN_W-1:0] max_len;
    } page_meta_t;

    // Table port controls
    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } tbl_req_t;

    // Saturate a byte length at the value size
    function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] len,
                                                   input logic [LEN_W-1:0] lim);
        return (len > lim) ? lim : len;
    endfunction

    // Mask keeping the top n bytes (n at most 8)
    function automatic logic [VALUE_W-1:0] top_mask(input logic [LEN_W-1:0] n);
        logic [6:0] sh;
        sh = 7'(VALUE_W) - {n, 3'b000};
        return {VALUE_W{1'b1}} << sh;
    endfunction

    // Lexicographic compare over the shorter length; shorter sorts first on a tie
    function automatic cmp_t lex_cmp(input logic [VALUE_W-1:0] a,
                                     input logic [LEN_W-1:0]   la,
                                     input logic [VALUE_W-1:0] b,
                                     input logic [LEN_W-1:0]   lb);
        logic [LEN_W-1:0]   n;
        logic [VALUE_W-1:0] m;
        logic [VALUE_W-1:0] x;
        logic [VALUE_W-1:0] y;
        cmp_t               r;
        n = (la < lb) ? la : lb;
        m = top_mask(n);
        x = a & m;
        y = b & m;
        if (x < y)
        begin
            r = CMP_LT;
        end
        else if (x > y)
        begin
            r = CMP_GT;
        end
        else if (la < lb)
        begin
            r = CMP_LT;
        end
        else if (la > lb)
        begin
            r = CMP_GT;
        end
        else
        begin
            r = CMP_EQ;
        end
        return r;
    endfunction

endpackage

// ===== design/pmmrf_table.sv =====
// ----------------------------------------------------------------------------
// pmmrf_table
// Page statistics memory: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module pmmrf_table #(
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = 10,
    parameter int DATA_W = 64
) (
    input  logic                      clk,
    input  pmmrf_pkg::tbl_req_t       req,
    input  logic [ADDR_W-1:0]         wr_addr,
    input  pmmrf_pkg::page_meta_t     wr_meta,
    input  logic [DATA_W-1:0]         wr_min,
    input  logic [DATA_W-1:0]         wr_max,
    input  logic [ADDR_W-1:0]         rd_addr,
    output pmmrf_pkg::page_meta_t     rd_meta,
    output logic [DATA_W-1:0]         rd_min,
    output logic [DATA_W-1:0]         rd_max
);
    import pmmrf_pkg::*;

    localparam int META_W = $bits(page_meta_t);
    localparam int WORD_W = META_W + 2 * DATA_W;

    typedef logic [WORD_W-1:0] word_t;

    word_t mem_array [DEPTH];
    word_t rd_word_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem_array[wr_addr] <= {wr_meta, wr_min, wr_max};
        end
    end

    // Read port, data held until the next read
    always_ff @(posedge clk)
    begin
        if (req.rd_en)
        begin
            rd_word_reg <= mem_array[rd_addr];
        end
    end

    assign rd_meta = rd_word_reg[WORD_W-1 -: META_W];
    assign rd_min  = rd_word_reg[2*DATA_W-1 -: DATA_W];
    assign rd_max  = rd_word_reg[DATA_W-1:0];

endmodule

// ===== design/page_minmax_range_filter_top.sv =====
// ----------------------------------------------------------------------------
// page_minmax_range_filter_top - per-page min/max table for range pruning
// Append and out-of-range query: result registered the cycle after acceptance,
// one transaction per cycle unless out_stall holds. Valid query: table read is
// registered, then result registered once output is free; input stalls meanwhile.
// Reset clears the page count and output valid; memory contents stay unset.
// ----------------------------------------------------------------------------
`include "page_minmax_range_filter_top_macros.svh"

module page_minmax_range_filter_top #(
    parameter int MAX_PAGES   = 1024,
    parameter int VALUE_BYTES = 8
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // input channel
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                func,
    input  logic [pmmrf_pkg::INDEX_W-1:0]       page_num,
    input  logic                                null_page,
    input  logic [pmmrf_pkg::VALUE_W-1:0]       low_value,
    input  logic [pmmrf_pkg::LEN_W-1:0]         low_len,
    input  logic [pmmrf_pkg::VALUE_W-1:0]       high_value,
    input  logic [pmmrf_pkg::LEN_W-1:0]         high_len,
    input  logic                                has_low,
    input  logic                                has_high,
    input  logic [pmmrf_pkg::LEN_W-1:0]         query_len,
    // output channel
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [pmmrf_pkg::STATUS_W-1:0]      status,
    output logic                                page_hit,
    output logic [pmmrf_pkg::STORED_W-1:0]      pages_stored
);
    import pmmrf_pkg::*;

    localparam int ADDR_W = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
    localparam int CNT_W  = $clog2(MAX_PAGES + 1);
    localparam int DATA_W = 8 * VALUE_BYTES;
    localparam int PAD_W  = VALUE_W - DATA_W;

    localparam logic [LEN_W-1:0] LEN_LIM  = LEN_W'(VALUE_BYTES);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_PAGES);

    // sequencer states
    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_READ = 1'b1;

    typedef logic [ADDR_W-1:0] addr_t;

    logic               state_reg;
    logic               state_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;

    // query held while the table is read
    logic [VALUE_W-1:0] q_low_reg;
    logic [VALUE_W-1:0] q_high_reg;
    logic [LEN_W-1:0]   q_len_reg;
    logic               q_has_low_reg;
    logic               q_has_high_reg;

    // output register
    logic                out_valid_reg;
    logic                out_valid_next;
    logic [STATUS_W-1:0] status_reg;
    logic [STATUS_W-1:0] status_next;
    logic                match_reg;
    logic                match_next;
    logic [STORED_W-1:0] stored_reg;
    logic [STORED_W-1:0] stored_next;

    logic               in_acc;
    logic               is_append;
    logic               full;
    logic               in_range;
    logic               out_free;
    logic               load_direct;
    logic               load_query;

    tbl_req_t           tbl_req;
    page_meta_t         wr_meta;
    logic [VALUE_W-1:0] min_full;
    logic [VALUE_W-1:0] max_full;
    logic [LEN_W-1:0]   min_len_c;
    logic [LEN_W-1:0]   max_len_c;
    page_meta_t         rd_meta;
    logic [DATA_W-1:0]  rd_min;
    logic [DATA_W-1:0]  rd_max;
    logic [VALUE_W-1:0] rd_min_ext;
    logic [VALUE_W-1:0] rd_max_ext;
    logic               fail_high;
    logic               fail_low;
    logic               query_match;

    // Handshake
    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = (state_reg == ST_READ) || !out_free;
    assign in_acc   = in_valid && !in_stall;

    // Decode of the incoming transaction
    assign is_append   = (func == FUNC_APPEND);
    assign full        = (count_reg == CNT_FULL);
    assign in_range    = (32'(page_num) < 32'(count_reg));
    assign load_direct = in_acc && (is_append || !in_range);
    assign load_query  = (state_reg == ST_READ) && out_free;

    // Append data, masked to the stated lengths
    assign min_len_c         = clamp_len(low_len, LEN_LIM);
    assign max_len_c         = clamp_len(high_len, LEN_LIM);
    assign min_full          = low_value & top_mask(min_len_c);
    assign max_full          = high_value & top_mask(max_len_c);
    assign wr_meta.null_flag = null_page;
    assign wr_meta.min_len   = min_len_c;
    assign wr_meta.max_len   = max_len_c;

    assign tbl_req.wr_en = in_acc && is_append && !full;
    assign tbl_req.rd_en = in_acc && !is_append && in_range;

    pmmrf_table #(
        .DEPTH  (MAX_PAGES),
        .ADDR_W (ADDR_W),
        .DATA_W (DATA_W)
    ) u_table (
        .clk     (clk),
        .req     (tbl_req),
        .wr_addr (addr_t'(count_reg)),
        .wr_meta (wr_meta),
        .wr_min  (min_full[VALUE_W-1 -: DATA_W]),
        .wr_max  (max_full[VALUE_W-1 -: DATA_W]),
        .rd_addr (addr_t'(page_num)),
        .rd_meta (rd_meta),
        .rd_min  (rd_min),
        .rd_max  (rd_max)
    );

    // Range test against the page just read
    assign rd_min_ext  = VALUE_W'(rd_min) << PAD_W;
    assign rd_max_ext  = VALUE_W'(rd_max) << PAD_W;
    assign fail_high   = q_has_high_reg && (rd_meta.min_len != '0) &&
                         (lex_cmp(q_high_reg, q_len_reg, rd_min_ext, rd_meta.min_len) == CMP_LT);
    assign fail_low    = q_has_low_reg && (rd_meta.max_len != '0) &&
                         (lex_cmp(q_low_reg, q_len_reg, rd_max_ext, rd_meta.max_len) == CMP_GT);
    assign query_match = !rd_meta.null_flag && !fail_high && !fail_low;

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (tbl_req.rd_en)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Page count
    always_comb
    begin
        count_next = count_reg;
        if (tbl_req.wr_en)
        begin
            count_next = count_reg + 1'b1;
        end
    end

    // Output register contents
    always_comb
    begin
        out_valid_next = out_valid_reg;
        status_next    = status_reg;
        match_next     = match_reg;
        stored_next    = stored_reg;
        if (load_direct)
        begin
            out_valid_next = 1'b1;
            match_next     = 1'b0;
            stored_next    = STORED_W'(count_next);
            if (is_append)
            begin
                status_next = full ? STATUS_FULL : STATUS_OK;
            end
            else
            begin
                status_next = STATUS_RANGE;
            end
        end
        else if (load_query)
        begin
            out_valid_next = 1'b1;
            status_next    = STATUS_OK;
            match_next     = query_match;
            stored_next    = STORED_W'(count_reg);
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        match_reg  <= match_next;
        stored_reg <= stored_next;
        if (tbl_req.rd_en)
        begin
            q_low_reg      <= low_value;
            q_high_reg     <= high_value;
            q_len_reg      <= clamp_len(query_len, LEN_LIM);
            q_has_low_reg  <= has_low;
            q_has_high_reg <= has_high;
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign page_hit     = match_reg;
    assign pages_stored = stored_reg;

    // Checks
    `PMMRF_ASSERT_SAME(a_count_bound, 1'b1, count_reg <= CNT_FULL, "page count above table size")
    `PMMRF_ASSERT_NEXT(a_full_hold, in_acc && is_append && full, $stable(count_reg), "count moved on full table")
    `PMMRF_ASSERT_NEXT(a_query_read, tbl_req.rd_en, state_reg == ST_READ, "query read not followed")
    `PMMRF_ASSERT_SAME(a_range_nomatch, out_valid_reg && status_reg != STATUS_OK, !match_reg, "match on error status")

endmodule
